/* design/contiguous_block_allocator_defines.svh */
// Assertion macros shared by the allocator design files.
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_DEFINES_SVH
`ifndef SYNTH
`define CBA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("allocator assertion failed");
`define CBA_ASSERT_NEVER(lbl, clk, rst_n, prop) \
  `CBA_ASSERT(lbl, clk, rst_n, !(prop))
`else
`define CBA_ASSERT(lbl, clk, rst_n, prop)
`define CBA_ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

/* design/cba_pkg.sv */
// Types and constants of the contiguous block allocator.
package cba_pkg;

  localparam int MaxBlocks = 1024;
  localparam int AddrW     = 10;
  localparam int LenW      = 11;
  localparam logic [LenW-1:0] LimitReset = LenW'(16);

  typedef enum logic [1:0] {
    OP_FIND  = 2'd0,
    OP_CHECK = 2'd1,
    OP_SET   = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]       operation;
    logic [AddrW-1:0] first_block;
    logic [LenW-1:0]  run_length;
    logic             mark_value;
  } alloc_req_t;

  typedef struct packed {
    logic             status;
    logic [AddrW-1:0] found_start;
    logic             range_free;
  } alloc_rsp_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic             data;
  } map_wr_t;

endpackage

/* design/cba_usage_map.sv */
// Usage mark store: one bit per block, cleared to free by a sweep after reset.
module cba_usage_map (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cba_pkg::map_wr_t          wr_i,
  input  logic [cba_pkg::AddrW-1:0] rd_addr_i,
  output logic                      rd_data_o,
  output logic                      clr_busy_o
);

  logic                     mem [cba_pkg::MaxBlocks];
  logic [cba_pkg::AddrW:0]  clr_q;
  logic [cba_pkg::AddrW:0]  clr_d;
  logic                     rd_data_q;

  assign clr_busy_o = ~clr_q[cba_pkg::AddrW];
  assign clr_d      = clr_busy_o ? clr_q + 1'b1 : clr_q;
  assign rd_data_o  = rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_o) begin
      mem[clr_q[cba_pkg::AddrW-1:0]] <= 1'b0;
    end else if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

endmodule

/* design/contiguous_block_allocator.sv */
// Top level of the first-fit contiguous block allocator.
// After reset the usage map is swept to free, one block a cycle, so the block
// takes no item until the sweep is done (configuration writes are taken).
// A set item writes its mark in the dispatch state. A find or check walks the
// map one block per cycle through its single read port: a find up to the
// effective block limit, a check up to its run length.
// One item is worked at a time; a finished result waits in the output register.
`include "contiguous_block_allocator_defines.svh"
module contiguous_block_allocator (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [cba_pkg::LenW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  cba_pkg::alloc_req_t      in_req_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output cba_pkg::alloc_rsp_t      out_rsp_o
);

  typedef enum logic [4:0] {
    ST_CLEAR    = 5'b00001,
    ST_IDLE     = 5'b00010,
    ST_DISPATCH = 5'b00100,
    ST_SCAN     = 5'b01000,
    ST_FINISH   = 5'b10000
  } state_e;

  state_e                     state_q, state_d;
  cba_pkg::alloc_req_t        req_q, req_d;
  cba_pkg::alloc_rsp_t        res_q, res_d;
  cba_pkg::alloc_rsp_t        out_q, out_d;
  logic                       out_valid_q, out_valid_d;
  logic [cba_pkg::LenW-1:0]   lim_q, lim_d;
  logic [cba_pkg::LenW-1:0]   ptr_q, ptr_d;
  logic [cba_pkg::LenW-1:0]   cnt_q, cnt_d;
  logic [cba_pkg::LenW-1:0]   base_q, base_d;
  logic [cba_pkg::LenW-1:0]   eff_lim;
  logic [cba_pkg::LenW-1:0]   ptr_inc;
  logic [cba_pkg::LenW-1:0]   cnt_inc;
  logic [cba_pkg::LenW-1:0]   run_new;
  logic [cba_pkg::LenW-1:0]   base_new;
  logic [cba_pkg::AddrW-1:0]  rd_addr;
  logic                       rd_data;
  logic                       clr_busy;
  logic                       out_load;
  cba_pkg::map_wr_t           map_wr;

  cba_usage_map u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (map_wr),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .clr_busy_o (clr_busy)
  );

  assign eff_lim  = (lim_q > cba_pkg::LenW'(cba_pkg::MaxBlocks)) ?
                    cba_pkg::LenW'(cba_pkg::MaxBlocks) : lim_q;
  assign ptr_inc  = ptr_q + 1'b1;
  assign cnt_inc  = cnt_q + 1'b1;
  assign run_new  = rd_data ? '0 : cnt_inc;
  assign base_new = rd_data ? ptr_inc : base_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign lim_d       = cfg_we_i ? cfg_wdata_i : lim_q;

  assign out_load    = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);
  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  assign out_d       = out_load ? res_q : out_q;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    base_d      = base_q;
    rd_addr     = ptr_inc[cba_pkg::AddrW-1:0];
    map_wr.en   = 1'b0;
    map_wr.addr = req_q.first_block;
    map_wr.data = req_q.mark_value;
    case (state_q)
      ST_CLEAR: begin
        if (!clr_busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_req_i;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        res_d   = '0;
        ptr_d   = '0;
        cnt_d   = '0;
        base_d  = '0;
        state_d = ST_FINISH;
        case (req_q.operation)
          cba_pkg::OP_FIND: begin
            rd_addr = '0;
            if (req_q.run_length == '0) begin
              res_d.status = 1'b0;
            end else if (eff_lim == '0) begin
              res_d.status = 1'b1;
            end else begin
              state_d = ST_SCAN;
            end
          end
          cba_pkg::OP_CHECK: begin
            rd_addr = req_q.first_block;
            ptr_d   = {1'b0, req_q.first_block};
            if (req_q.run_length == '0) begin
              res_d.range_free = 1'b1;
            end else if ({1'b0, req_q.first_block} >= eff_lim) begin
              res_d.range_free = 1'b0;
            end else begin
              state_d = ST_SCAN;
            end
          end
          cba_pkg::OP_SET: begin
            map_wr.en = 1'b1;
          end
          default: begin
            res_d.status = 1'b1;
          end
        endcase
      end
      ST_SCAN: begin
        if (req_q.operation == cba_pkg::OP_FIND) begin
          if ((ptr_inc >= eff_lim) || (run_new == req_q.run_length)) begin
            state_d = ST_FINISH;
            if (run_new == req_q.run_length) begin
              res_d.found_start = base_new[cba_pkg::AddrW-1:0];
            end else begin
              res_d.status = 1'b1;
            end
          end else begin
            ptr_d  = ptr_inc;
            cnt_d  = run_new;
            base_d = base_new;
          end
        end else begin
          if (rd_data) begin
            state_d = ST_FINISH;
          end else if (cnt_inc == req_q.run_length) begin
            res_d.range_free = 1'b1;
            state_d          = ST_FINISH;
          end else if (ptr_inc >= eff_lim) begin
            state_d = ST_FINISH;
          end else begin
            ptr_d = ptr_inc;
            cnt_d = cnt_inc;
          end
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
      lim_q       <= cba_pkg::LimitReset;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      lim_q       <= lim_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    res_q  <= res_d;
    out_q  <= out_d;
    ptr_q  <= ptr_d;
    cnt_q  <= cnt_d;
    base_q <= base_d;
  end

  `CBA_ASSERT(a_state_onehot, clk_i, rst_ni, $onehot(state_q))
  `CBA_ASSERT(a_scan_in_map, clk_i, rst_ni, (state_q == ST_SCAN) |-> (ptr_q[cba_pkg::AddrW] == 1'b0))
  `CBA_ASSERT(a_scan_short, clk_i, rst_ni, (state_q == ST_SCAN) |-> (cnt_q < req_q.run_length))
  `CBA_ASSERT_NEVER(a_ready_clearing, clk_i, rst_ni, in_ready_o && clr_busy)
  `CBA_ASSERT(a_finish_hold, clk_i, rst_ni, (state_q == ST_FINISH && out_valid_q && !out_ready_i) |=> (state_q == ST_FINISH))

endmodule
